// ===== rtl/core/mdtg_pkg.sv =====
`timescale 1ns / 1ps

package mdtg_pkg;

   localparam int unsigned FRAME_SAMPLES_DEFAULT = 184;

   localparam int unsigned ADDR_W   = 24;
   localparam int unsigned BYTES_W  = 10;
   localparam int unsigned CSR_W    = 31;
   localparam int unsigned CSR_IX_W = 3;
   localparam int unsigned MUL_A_W  = 32;
   localparam int unsigned MUL_B_W  = 31;
   localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
   localparam int unsigned Q_SHIFT  = 28;
   localparam int unsigned DVD_W    = PROD_W - Q_SHIFT;
   localparam int unsigned CNT_W    = $clog2(DVD_W + 1);
   localparam int unsigned FRAC_W   = 15;

   localparam logic [31:0] PHASE_ONE  = 32'h1000_0000;
   localparam logic [31:0] PHASE_TWO  = 32'h2000_0000;
   localparam logic [31:0] PHASE_FOUR = 32'h4000_0000;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_RING_BASE   = 3'd0,
      CSR_RING_LENGTH = 3'd1,
      CSR_DELAY_START = 3'd2,
      CSR_DELAY_END   = 3'd3,
      CSR_LFO_STEP    = 3'd4,
      CSR_LFO_DEPTH   = 3'd5,
      CSR_MOD_ENABLE  = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHASE,
      ST_LFO,
      ST_MAG,
      ST_DIV_LOAD,
      ST_DIV,
      ST_PITCH,
      ST_POS,
      ST_ADDR,
      ST_RING,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/modulated_delay_tap_generator.sv =====
`timescale 1ns / 1ps

// Modulated delay tap generator: one beat on req_ per audio frame (the ring
// write-head byte address), one beat on rsp_ per frame carrying the DMA read
// (one or two segments) and the resampler settings for that frame.
// Registers are written on the csr_ port with csr_we, csr_index and csr_wdata,
// by the user only while the block is idle; the block does not enforce this.
// With modulation off, the block goes from idle straight to the ring step.
// With modulation on, a shared 32x31 multiplier is used three times and a
// restoring divider produces one quotient bit per cycle.
// With a zero delay span the divider is skipped.
// One frame is in flight at a time: req_stall is high from the accepted beat
// until the result has been loaded into the rsp_ output register, so a new
// frame is taken only after the last one's result is in that register.
// If the receiver holds rsp_stall, the result waits in the output register
// and the block holds its last step until the register frees.
// Reset (synchronous) restores register defaults, clears the LFO phase,
// fractional position and tap offset, and marks the next modulated frame as
// the first.
module modulated_delay_tap_generator #(
   parameter int unsigned FRAME_SAMPLES = mdtg_pkg::FRAME_SAMPLES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_we,
   input  logic [mdtg_pkg::CSR_IX_W-1:0]    csr_index,
   input  logic [mdtg_pkg::CSR_W-1:0]       csr_wdata,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mdtg_pkg::ADDR_W-1:0]      req_ring_head,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mdtg_pkg::ADDR_W-1:0]      rsp_read_addr_first,
   output logic [mdtg_pkg::BYTES_W-1:0]     rsp_read_bytes_first,
   output logic [mdtg_pkg::ADDR_W-1:0]      rsp_read_addr_second,
   output logic [mdtg_pkg::BYTES_W-1:0]     rsp_read_bytes_second,
   output logic [2:0]                       rsp_skip_bytes,
   output logic [15:0]                      rsp_resample_pitch,
   output logic                             rsp_resample_first,
   output logic                             rsp_resample_active
);

   localparam int unsigned N_W   = $clog2(2 * FRAME_SAMPLES + 4);
   localparam int unsigned POS_W = mdtg_pkg::FRAC_W + N_W;
   localparam int unsigned AW    = mdtg_pkg::ADDR_W;
   localparam int unsigned BW    = mdtg_pkg::BYTES_W;

   mdtg_pkg::state_type state_ff, state_in;

   // configuration
   logic [23:0] ring_base_ff;
   logic [15:0] ring_length_ff;
   logic [15:0] delay_start_ff;
   logic [15:0] delay_end_ff;
   logic [28:0] lfo_step_ff;
   logic [30:0] lfo_depth_ff;
   logic        mod_enable_ff;

   // frame state
   logic [31:0]                     lfo_phase_ff, lfo_phase_in;
   logic [mdtg_pkg::FRAC_W-1:0]     frac_ff, frac_in;
   logic [31:0]                     tap_offset_ff, tap_offset_in;
   logic                            first_frame_ff, first_frame_in;

   // working registers
   logic [23:0]                     head_ff, head_in;
   logic [mdtg_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [31:0]                     tmag_ff, tmag_in;
   logic                            tneg_ff, tneg_in;
   logic [15:0]                     span_abs_ff, span_abs_in;
   logic                            span_neg_ff, span_neg_in;
   logic                            span_zero_ff, span_zero_in;
   logic                            prod_zero_ff, prod_zero_in;
   logic [mdtg_pkg::DVD_W-1:0]      dq_ff, dq_in;
   logic [15:0]                     rem_ff, rem_in;
   logic [mdtg_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [15:0]                     pitch_ff, pitch_in;
   logic [31:0]                     addr_ff, addr_in;
   logic [N_W-1:0]                  nsamp_ff, nsamp_in;
   logic [2:0]                      skip_ff, skip_in;
   logic                            act_ff, act_in;
   logic                            first_out_ff, first_out_in;
   logic [31:0]                     radj_ff, radj_in;
   logic [31:0]                     end_ff, end_in;
   logic [31:0]                     rend_ff, rend_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]   out_addr1_ff, out_addr1_in;
   logic [BW-1:0]   out_bytes1_ff, out_bytes1_in;
   logic [AW-1:0]   out_addr2_ff, out_addr2_in;
   logic [BW-1:0]   out_bytes2_ff, out_bytes2_in;
   logic [2:0]      out_skip_ff, out_skip_in;
   logic [15:0]     out_pitch_ff, out_pitch_in;
   logic            out_first_ff, out_first_in;
   logic            out_act_ff, out_act_in;

   // shared multiplier operands
   logic [mdtg_pkg::MUL_A_W-1:0] mul_a;
   logic [mdtg_pkg::MUL_B_W-1:0] mul_b;

   logic        req_accept;
   logic        slot_free;
   logic [31:0] ph_sum;
   logic [31:0] ph_new;
   logic [31:0] ph_abs;
   logic [16:0] span_diff;
   logic [16:0] div_shift;
   logic        div_ge;
   logic        q_neg;
   logic [16:0] pitch_wide;
   logic [POS_W-1:0] pos;
   logic [N_W-1:0]   n_whole;
   logic [31:0] tap_addr;
   logic [1:0]  slack;
   logic [31:0] len2;
   logic [31:0] wrap_first;
   logic [31:0] wrap_second;
   logic [31:0] plain_bytes;
   logic        wraps;

   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != mdtg_pkg::ST_IDLE);

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_addr_first   = out_addr1_ff;
   assign rsp_read_bytes_first  = out_bytes1_ff;
   assign rsp_read_addr_second  = out_addr2_ff;
   assign rsp_read_bytes_second = out_bytes2_ff;
   assign rsp_skip_bytes        = out_skip_ff;
   assign rsp_resample_pitch    = out_pitch_ff;
   assign rsp_resample_first    = out_first_ff;
   assign rsp_resample_active   = out_act_ff;

   // operand select for the one multiplier
   always_comb begin
      case (state_ff)
         mdtg_pkg::ST_PHASE: begin
            mul_a = 32'(lfo_step_ff);
            mul_b = mdtg_pkg::MUL_B_W'(FRAME_SAMPLES);
         end
         mdtg_pkg::ST_MAG: begin
            mul_a = tmag_ff;
            mul_b = lfo_depth_ff;
         end
         mdtg_pkg::ST_POS: begin
            mul_a = 32'(pitch_ff);
            mul_b = mdtg_pkg::MUL_B_W'(FRAME_SAMPLES);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      lfo_phase_in   = lfo_phase_ff;
      frac_in        = frac_ff;
      tap_offset_in  = tap_offset_ff;
      first_frame_in = first_frame_ff;
      head_in        = head_ff;
      prod_in        = mdtg_pkg::PROD_W'(mul_a) * mdtg_pkg::PROD_W'(mul_b);
      tmag_in        = tmag_ff;
      tneg_in        = tneg_ff;
      span_abs_in    = span_abs_ff;
      span_neg_in    = span_neg_ff;
      span_zero_in   = span_zero_ff;
      prod_zero_in   = prod_zero_ff;
      dq_in          = dq_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      pitch_in       = pitch_ff;
      addr_in        = addr_ff;
      nsamp_in       = nsamp_ff;
      skip_in        = skip_ff;
      act_in         = act_ff;
      first_out_in   = first_out_ff;
      radj_in        = radj_ff;
      end_in         = end_ff;
      rend_in        = rend_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      out_addr1_in   = out_addr1_ff;
      out_bytes1_in  = out_bytes1_ff;
      out_addr2_in   = out_addr2_ff;
      out_bytes2_in  = out_bytes2_ff;
      out_skip_in    = out_skip_ff;
      out_pitch_in   = out_pitch_ff;
      out_first_in   = out_first_ff;
      out_act_in     = out_act_ff;

      // LFO phase advance and triangle fold
      ph_sum = lfo_phase_ff + prod_ff[31:0];
      ph_new = ($signed(ph_sum) > $signed(mdtg_pkg::PHASE_TWO))
               ? ph_sum - mdtg_pkg::PHASE_FOUR : ph_sum;
      ph_abs = ph_new[31] ? (~ph_new + 32'd1) : ph_new;

      span_diff = {1'b0, delay_end_ff} - {1'b0, delay_start_ff};

      // restoring divider step
      div_shift = {rem_ff, dq_ff[mdtg_pkg::DVD_W-1]};
      div_ge    = (div_shift >= {1'b0, span_abs_ff});

      // pitch from quotient
      q_neg = tneg_ff ^ span_neg_ff;
      if (span_zero_ff) begin
         if (prod_zero_ff) begin
            pitch_wide = 17'd32768;
         end else if (tneg_ff) begin
            pitch_wide = 17'd65535;
         end else begin
            pitch_wide = 17'd0;
         end
      end else if (q_neg) begin
         if (dq_ff > mdtg_pkg::DVD_W'(32767)) begin
            pitch_wide = 17'd65535;
         end else begin
            pitch_wide = 17'd32768 + {2'b00, dq_ff[14:0]};
         end
      end else begin
         if (dq_ff > mdtg_pkg::DVD_W'(32768)) begin
            pitch_wide = 17'd0;
         end else begin
            pitch_wide = 17'd32768 - dq_ff[16:0];
         end
      end

      // sample count and tap address
      pos      = POS_W'(frac_ff) + prod_ff[POS_W-1:0];
      n_whole  = pos[POS_W-1:mdtg_pkg::FRAC_W];
      tap_addr = 32'(head_ff) - {15'd0, delay_end_ff, 1'b0} + {tap_offset_ff[30:0], 1'b0};
      slack    = tap_addr[2:1];

      // ring split
      len2        = {15'd0, ring_length_ff, 1'b0};
      wraps       = (end_ff > rend_ff);
      wrap_first  = rend_ff - radj_ff;
      wrap_second = end_ff - rend_ff;
      plain_bytes = {31'(nsamp_ff), 1'b0};

      case (state_ff)
         mdtg_pkg::ST_IDLE: begin
            if (req_accept) begin
               head_in = req_ring_head;
               if (mod_enable_ff) begin
                  state_in = mdtg_pkg::ST_PHASE;
               end else begin
                  addr_in      = 32'(req_ring_head) - {15'd0, delay_end_ff, 1'b0};
                  nsamp_in     = N_W'(FRAME_SAMPLES);
                  skip_in      = 3'd0;
                  pitch_in     = 16'd0;
                  act_in       = 1'b0;
                  first_out_in = 1'b0;
                  state_in     = mdtg_pkg::ST_RING;
               end
            end
         end
         mdtg_pkg::ST_PHASE: begin
            state_in = mdtg_pkg::ST_LFO;
         end
         mdtg_pkg::ST_LFO: begin
            lfo_phase_in = ph_new;
            if (ph_abs >= mdtg_pkg::PHASE_ONE) begin
               tneg_in = 1'b0;
               tmag_in = ph_abs - mdtg_pkg::PHASE_ONE;
            end else begin
               tneg_in = 1'b1;
               tmag_in = mdtg_pkg::PHASE_ONE - ph_abs;
            end
            span_neg_in  = span_diff[16];
            span_zero_in = (span_diff == 17'd0);
            span_abs_in  = span_diff[16] ? 16'(-span_diff) : span_diff[15:0];
            state_in     = mdtg_pkg::ST_MAG;
         end
         mdtg_pkg::ST_MAG: begin
            state_in = mdtg_pkg::ST_DIV_LOAD;
         end
         mdtg_pkg::ST_DIV_LOAD: begin
            dq_in        = prod_ff[mdtg_pkg::PROD_W-1:mdtg_pkg::Q_SHIFT];
            prod_zero_in = (prod_ff == '0);
            rem_in       = 16'd0;
            cnt_in       = mdtg_pkg::CNT_W'(mdtg_pkg::DVD_W);
            state_in     = span_zero_ff ? mdtg_pkg::ST_PITCH : mdtg_pkg::ST_DIV;
         end
         mdtg_pkg::ST_DIV: begin
            rem_in = div_ge ? 16'(div_shift - {1'b0, span_abs_ff}) : div_shift[15:0];
            dq_in  = {dq_ff[mdtg_pkg::DVD_W-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == mdtg_pkg::CNT_W'(1)) begin
               state_in = mdtg_pkg::ST_PITCH;
            end
         end
         mdtg_pkg::ST_PITCH: begin
            pitch_in = pitch_wide[15:0];
            state_in = mdtg_pkg::ST_POS;
         end
         mdtg_pkg::ST_POS: begin
            state_in = mdtg_pkg::ST_ADDR;
         end
         mdtg_pkg::ST_ADDR: begin
            frac_in        = pos[mdtg_pkg::FRAC_W-1:0];
            addr_in        = {tap_addr[31:3], 2'b00, tap_addr[0]};
            nsamp_in       = n_whole + N_W'(slack);
            skip_in        = {slack, 1'b0};
            act_in         = 1'b1;
            first_out_in   = first_frame_ff;
            first_frame_in = 1'b0;
            tap_offset_in  = tap_offset_ff + 32'(n_whole) - 32'(FRAME_SAMPLES);
            state_in       = mdtg_pkg::ST_RING;
         end
         mdtg_pkg::ST_RING: begin
            radj_in  = (addr_ff < 32'(ring_base_ff)) ? addr_ff + len2 : addr_ff;
            rend_in  = 32'(ring_base_ff) + len2;
            end_in   = ((addr_ff < 32'(ring_base_ff)) ? addr_ff + len2 : addr_ff)
                       + {31'(nsamp_ff), 1'b0};
            state_in = mdtg_pkg::ST_EMIT;
         end
         mdtg_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_addr1_in = radj_ff[AW-1:0];
               if (wraps) begin
                  out_bytes1_in = {wrap_first[BW-1:1], 1'b0};
                  out_addr2_in  = ring_base_ff;
                  out_bytes2_in = {wrap_second[BW-1:1], 1'b0};
               end else begin
                  out_bytes1_in = plain_bytes[BW-1:0];
                  out_addr2_in  = '0;
                  out_bytes2_in = '0;
               end
               out_skip_in  = skip_ff;
               out_pitch_in = pitch_ff;
               out_first_in = first_out_ff;
               out_act_in   = act_ff;
               state_in     = mdtg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mdtg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mdtg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_base_ff   <= 24'd0;
         ring_length_ff <= 16'd4096;
         delay_start_ff <= 16'd0;
         delay_end_ff   <= 16'd8;
         lfo_step_ff    <= 29'd0;
         lfo_depth_ff   <= 31'd0;
         mod_enable_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mdtg_pkg::CSR_RING_BASE:   ring_base_ff   <= csr_wdata[23:0];
            mdtg_pkg::CSR_RING_LENGTH: ring_length_ff <= csr_wdata[15:0];
            mdtg_pkg::CSR_DELAY_START: delay_start_ff <= csr_wdata[15:0];
            mdtg_pkg::CSR_DELAY_END:   delay_end_ff   <= csr_wdata[15:0];
            mdtg_pkg::CSR_LFO_STEP:    lfo_step_ff    <= csr_wdata[28:0];
            mdtg_pkg::CSR_LFO_DEPTH:   lfo_depth_ff   <= csr_wdata[30:0];
            mdtg_pkg::CSR_MOD_ENABLE:  mod_enable_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_phase_ff   <= '0;
         frac_ff        <= '0;
         tap_offset_ff  <= '0;
         first_frame_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         lfo_phase_ff   <= lfo_phase_in;
         frac_ff        <= frac_in;
         tap_offset_ff  <= tap_offset_in;
         first_frame_ff <= first_frame_in;
         rsp_valid_ff   <= rsp_valid_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff       <= head_in;
      prod_ff       <= prod_in;
      tmag_ff       <= tmag_in;
      tneg_ff       <= tneg_in;
      span_abs_ff   <= span_abs_in;
      span_neg_ff   <= span_neg_in;
      span_zero_ff  <= span_zero_in;
      prod_zero_ff  <= prod_zero_in;
      dq_ff         <= dq_in;
      rem_ff        <= rem_in;
      pitch_ff      <= pitch_in;
      addr_ff       <= addr_in;
      nsamp_ff      <= nsamp_in;
      skip_ff       <= skip_in;
      act_ff        <= act_in;
      first_out_ff  <= first_out_in;
      radj_ff       <= radj_in;
      end_ff        <= end_in;
      rend_ff       <= rend_in;
      out_addr1_ff  <= out_addr1_in;
      out_bytes1_ff <= out_bytes1_in;
      out_addr2_ff  <= out_addr2_in;
      out_bytes2_ff <= out_bytes2_in;
      out_skip_ff   <= out_skip_in;
      out_pitch_ff  <= out_pitch_in;
      out_first_ff  <= out_first_in;
      out_act_ff    <= out_act_in;
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input beat taken but block not busy");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == mdtg_pkg::ST_EMIT)
      else $error("result beat raised outside emit step");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_act_ff |-> out_pitch_ff == 16'd0 && out_skip_ff == 3'd0
                                       && !out_first_ff)
      else $error("resampler fields set on unmodulated beat");

   a_skip_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !out_skip_ff[0] && !out_bytes1_ff[0] && !out_bytes2_ff[0])
      else $error("odd byte count or skip");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == mdtg_pkg::ST_DIV |-> cnt_ff != '0)
      else $error("divider running with zero count");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned FRAME_LEN          = mdtg_pkg::FRAME_SAMPLES_DEFAULT;
   localparam int unsigned QUIET_LIMIT        = 4000;
   localparam int unsigned HOLD_OFF_CYCLES    = 300;
   localparam int unsigned HOLD_OFF_AT        = 60;
   localparam int unsigned FRAMES_PER_SETTING = 80;
   localparam int unsigned SETTING_COUNT      = 8;
   localparam int unsigned MAX_REPORTS        = 20;

   typedef struct packed {
      bit [mdtg_pkg::ADDR_W-1:0]  addr_first;
      bit [mdtg_pkg::BYTES_W-1:0] bytes_first;
      bit [mdtg_pkg::ADDR_W-1:0]  addr_second;
      bit [mdtg_pkg::BYTES_W-1:0] bytes_second;
      bit [2:0]                   skip_bytes;
      bit [15:0]                  pitch;
      bit                         first;
      bit                         active;
   } tap_read_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [mdtg_pkg::CSR_IX_W-1:0] csr_index = '0;
   logic [mdtg_pkg::CSR_W-1:0]    csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [mdtg_pkg::ADDR_W-1:0]   req_ring_head = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mdtg_pkg::ADDR_W-1:0]   rsp_read_addr_first;
   logic [mdtg_pkg::BYTES_W-1:0]  rsp_read_bytes_first;
   logic [mdtg_pkg::ADDR_W-1:0]   rsp_read_addr_second;
   logic [mdtg_pkg::BYTES_W-1:0]  rsp_read_bytes_second;
   logic [2:0]                    rsp_skip_bytes;
   logic [15:0]                   rsp_resample_pitch;
   logic                          rsp_resample_first;
   logic                          rsp_resample_active;

   // predictor copy of the registers and tap state
   bit [23:0] ring_base_cfg;
   bit [15:0] ring_len_cfg = 16'd4096;
   bit [15:0] win_start_cfg;
   bit [15:0] win_end_cfg = 16'd8;
   bit [28:0] lfo_step_cfg;
   bit [30:0] lfo_depth_cfg;
   bit        mod_on_cfg;
   bit [31:0] lfo_phase;
   bit [14:0] frac_pos;
   bit [31:0] tap_drift;
   bit        first_pending = 1'b1;

   bit [mdtg_pkg::ADDR_W-1:0] head_queue[$];
   tap_read_type              expected_taps[$];
   tap_read_type              oldest_tap;

   int unsigned sender_idle_pct = 16;
   int unsigned receiver_stall_pct = 66;
   int unsigned frames_accepted, results_seen, mismatch_count;
   int unsigned modulated_frames, split_reads, clamped_pitches, setting_count;
   int unsigned hold_left, quiet_cycles;
   bit          hold_done;

   modulated_delay_tap_generator u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_ring_head         (req_ring_head),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_read_addr_first   (rsp_read_addr_first),
      .rsp_read_bytes_first  (rsp_read_bytes_first),
      .rsp_read_addr_second  (rsp_read_addr_second),
      .rsp_read_bytes_second (rsp_read_bytes_second),
      .rsp_skip_bytes        (rsp_skip_bytes),
      .rsp_resample_pitch    (rsp_resample_pitch),
      .rsp_resample_first    (rsp_resample_first),
      .rsp_resample_active   (rsp_resample_active)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic tap_read_type ring_fetch(bit [31:0] addr, bit [31:0] nsamp);
      tap_read_type r;
      bit [31:0] len2, ring_end, stop, diff, over;
      r = '0;
      len2 = {15'd0, ring_len_cfg, 1'b0};
      ring_end = {8'd0, ring_base_cfg} + len2;
      if (addr < {8'd0, ring_base_cfg}) begin
         addr = addr + len2;
      end
      stop = addr + (nsamp << 1);
      r.addr_first = addr[23:0];
      if (stop > ring_end) begin
         diff = ring_end - addr;
         over = stop - ring_end;
         r.bytes_first = {diff[9:1], 1'b0};
         r.addr_second = ring_base_cfg;
         r.bytes_second = {over[9:1], 1'b0};
         split_reads++;
      end else begin
         r.bytes_first = {nsamp[8:0], 1'b0};
      end
      return r;
   endfunction

   function automatic tap_read_type predict_tap(bit [mdtg_pkg::ADDR_W-1:0] head);
      tap_read_type r;
      bit [31:0] addr, pos, count, slack, pitch_u;
      bit [63:0] mag_product, divisor;
      longint    ph, tri_val, span, q, pitch;
      bit        tneg;
      if (!mod_on_cfg) begin
         r = ring_fetch({8'd0, head} - {15'd0, win_end_cfg, 1'b0}, FRAME_LEN);
      end else begin
         lfo_phase = lfo_phase + {3'd0, lfo_step_cfg} * FRAME_LEN;
         if ($signed(lfo_phase) > 32'sh2000_0000) begin
            lfo_phase = lfo_phase - 32'h4000_0000;
         end
         ph = $signed(lfo_phase);
         tri_val = (ph < 0 ? -ph : ph) - 64'sd268435456;
         tneg = tri_val < 0;
         mag_product = tneg ? -tri_val : tri_val;
         mag_product = mag_product * {33'd0, lfo_depth_cfg};
         span = win_end_cfg;
         span = span - win_start_cfg;
         if (span == 0) begin
            // no span: saturate towards the sign of the triangle
            if (mag_product == 0) begin
               q = 0;
            end else begin
               q = tneg ? -64'sd1048576 : 64'sd1048576;
            end
         end else begin
            divisor = span < 0 ? -span : span;
            divisor = divisor << 28;
            q = mag_product / divisor;
            if (tneg != (span < 0)) begin
               q = -q;
            end
         end
         pitch = 64'sd32768 - q;
         if (pitch < 0 || pitch > 65535) begin
            pitch = pitch < 0 ? 64'sd0 : 64'sd65535;
            clamped_pitches++;
         end
         pitch_u = 32'(pitch);
         pos = {17'd0, frac_pos} + pitch_u * FRAME_LEN;
         count = pos >> 15;
         frac_pos = pos[14:0];
         addr = {8'd0, head} - (({16'd0, win_end_cfg} - tap_drift) << 1);
         slack = {30'd0, addr[2:1]};
         r = ring_fetch(addr - (slack << 1), count + slack);
         r.skip_bytes = {addr[2:1], 1'b0};
         r.pitch = pitch_u[15:0];
         r.first = first_pending;
         r.active = 1'b1;
         first_pending = 1'b0;
         tap_drift = tap_drift + count - FRAME_LEN;
         modulated_frames++;
      end
      return r;
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         end
      end
   endfunction

   // input beats: one head address per frame
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_taps.push_back(predict_tap(req_ring_head));
            frames_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (head_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_ring_head <= head_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
               req_ring_head <= 24'($urandom);
            end
         end
      end
   end

   // result beats
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_taps.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                        $time, rsp_read_addr_first);
            end else begin
               oldest_tap = expected_taps.pop_front();
               check_field("read_addr_first", oldest_tap.addr_first, rsp_read_addr_first);
               check_field("read_bytes_first", oldest_tap.bytes_first, rsp_read_bytes_first);
               check_field("read_addr_second", oldest_tap.addr_second, rsp_read_addr_second);
               check_field("read_bytes_second", oldest_tap.bytes_second,
                           rsp_read_bytes_second);
               check_field("skip_bytes", oldest_tap.skip_bytes, rsp_skip_bytes);
               check_field("resample_pitch", oldest_tap.pitch, rsp_resample_pitch);
               check_field("resample_first", oldest_tap.first, rsp_resample_first);
               check_field("resample_active", oldest_tap.active, rsp_resample_active);
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (results_seen == HOLD_OFF_AT && !hold_done) begin
            // long hold-off so the frame backs up into req_stall
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(99) < receiver_stall_pct;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(mdtg_pkg::csr_index_type ix, bit [mdtg_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= ix;
      csr_wdata <= value;
      case (ix)
         mdtg_pkg::CSR_RING_BASE:   ring_base_cfg = value[23:0];
         mdtg_pkg::CSR_RING_LENGTH: ring_len_cfg = value[15:0];
         mdtg_pkg::CSR_DELAY_START: win_start_cfg = value[15:0];
         mdtg_pkg::CSR_DELAY_END:   win_end_cfg = value[15:0];
         mdtg_pkg::CSR_LFO_STEP:    lfo_step_cfg = value[28:0];
         mdtg_pkg::CSR_LFO_DEPTH:   lfo_depth_cfg = value[30:0];
         mdtg_pkg::CSR_MOD_ENABLE:  mod_on_cfg = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(bit [23:0] base, bit [15:0] len, bit [15:0] dstart,
                                bit [15:0] dend, bit [28:0] step, bit [30:0] depth,
                                bit mod_en);
      write_reg(mdtg_pkg::CSR_RING_BASE, mdtg_pkg::CSR_W'(base));
      write_reg(mdtg_pkg::CSR_RING_LENGTH, mdtg_pkg::CSR_W'(len));
      write_reg(mdtg_pkg::CSR_DELAY_START, mdtg_pkg::CSR_W'(dstart));
      write_reg(mdtg_pkg::CSR_DELAY_END, mdtg_pkg::CSR_W'(dend));
      write_reg(mdtg_pkg::CSR_LFO_STEP, mdtg_pkg::CSR_W'(step));
      write_reg(mdtg_pkg::CSR_LFO_DEPTH, mdtg_pkg::CSR_W'(depth));
      write_reg(mdtg_pkg::CSR_MOD_ENABLE, mdtg_pkg::CSR_W'(mod_en));
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   task automatic random_setting(bit mod_en);
      bit [23:0]   base;
      bit [15:0]   len, dstart, dend;
      bit [28:0]   step;
      bit [30:0]   depth;
      int unsigned pick, span;
      pick = $urandom_range(3);
      base = pick == 0 ? 24'd0 : pick == 1 ? 24'hFFFFFF : 24'($urandom);
      pick = $urandom_range(3);
      len = pick == 0 ? 16'd16 : pick == 1 ? 16'hFFFF : 16'($urandom_range(16, 4096));
      dstart = 16'($urandom_range(0, 8191)) & 16'hFFF8;
      pick = $urandom_range(9);
      if (pick == 0) begin
         dend = dstart;
      end else if (pick == 1) begin
         dend = 16'($urandom_range(0, 32'(dstart)));
      end else if (pick == 2) begin
         dend = 16'hFFFF;
      end else begin
         dend = dstart + 16'($urandom_range(8, 2000));
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
         step = 29'h1000_0000;
      end else if (pick == 1) begin
         step = 29'($urandom_range(0, 32'h1000_0000));
      end else begin
         step = 29'($urandom_range(0, 1 << 18));
      end
      span = dend > dstart ? 32'(dend - dstart) : 1;
      pick = $urandom_range(9);
      if (pick == 0) begin
         depth = 31'h7FFF_FFFF;
      end else if (pick == 1) begin
         depth = 31'($urandom);
      end else begin
         depth = 31'($urandom_range(0, span * 32768));
      end
      apply_setting(base, len, dstart, dend, step, depth, mod_en);
   endtask

   function automatic bit [mdtg_pkg::ADDR_W-1:0] random_head();
      bit [31:0] offset;
      if ($urandom_range(4) == 0) begin
         return 24'($urandom);
      end
      offset = 32'($urandom_range(0, 32'(ring_len_cfg) - 1)) << 1;
      return ring_base_cfg + offset[23:0] + 24'($urandom_range(1));
   endfunction

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (head_queue.size() != 0 || req_valid || expected_taps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      bit [31:0]   inv23, gap;
      int unsigned block;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // fixed delay at reset defaults, ring edges and bit patterns
      head_queue = '{24'h000000, 24'h000010, 24'h001FF0, 24'hFFFFFF, 24'hAAAAAA, 24'h555555};
      wait_idle();

      // still LFO, unity pitch on a minimum ring
      apply_setting(24'h100000, 16'd16, 16'd0, 16'd8, 29'd0, 31'd0, 1'b1);
      head_queue = '{24'h100006, 24'h100002};
      wait_idle();

      // zero span, triangle below zero
      apply_setting(24'h000000, 16'd4096, 16'd64, 16'd64, 29'd0, 31'h8000, 1'b1);
      head_queue = '{24'h000804, 24'h001000};
      wait_idle();

      // zero span, triangle above zero then phase wrap past two
      apply_setting(24'h000000, 16'd4096, 16'd64, 16'd64, 29'h20_0000, 31'h8000, 1'b1);
      head_queue = '{24'h000A00, 24'h000A02};
      wait_idle();

      // zero span with the triangle at exactly zero: step lands the phase on one
      inv23 = 32'd23;
      repeat (4) inv23 = inv23 * (32'd2 - 32'd23 * inv23);
      gap = (32'h1000_0000 - lfo_phase) >> 3;
      write_reg(mdtg_pkg::CSR_LFO_STEP, mdtg_pkg::CSR_W'(29'(gap * inv23)));
      @(posedge clock);
      csr_we <= 1'b0;
      head_queue = '{24'h000C00};
      wait_idle();

      // negative span
      apply_setting(24'h020000, 16'd2048, 16'd1000, 16'd200, 29'h4_0000, 31'h0100_0000, 1'b1);
      head_queue = '{24'h020400, 24'h020FFE};
      wait_idle();

      // step of 0x1000_0000, largest depth, ring at the top of the address space
      apply_setting(24'hFFFFFF, 16'hFFFF, 16'd0, 16'd8, 29'h1000_0000, 31'h7FFF_FFFF, 1'b1);
      head_queue = '{24'hFFFFFF, 24'h000000, 24'h7FFFFE};
      wait_idle();

      apply_setting(24'hFFFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 29'd0, 31'd0, 1'b0);
      head_queue = '{24'h000000, 24'hFFFFFF};
      wait_idle();

      for (block = 0; block < SETTING_COUNT; block++) begin
         if (block == 3) begin
            sender_idle_pct = 66;
            receiver_stall_pct = 16;
         end else if (block == 6) begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         random_setting(block != 2 && block != 5);
         repeat (FRAMES_PER_SETTING) head_queue.push_back(random_head());
         wait_idle();
      end

      repeat (60) @(posedge clock);
      if (expected_taps.size() != 0) begin
         mismatch_count++;
         $display("%0t: results missing, expected %0d more, actual 0", $time,
                  expected_taps.size());
      end
      $display("covered %0d frames over %0d register sets, %0d of them modulated",
               frames_accepted, setting_count, modulated_frames);
      $display("%0d reads split at the ring end, %0d pitches saturated",
               split_reads, clamped_pitches);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
